/* hw/rtl/grp_pkg.sv */
// grp_pkg: shared constants, types and helper functions of the grid rectangle packer
`timescale 1ns / 1ps

package grp_pkg;

  // grid size limits
  localparam int unsigned MAX_RECTS = 64;
  localparam int unsigned GRID_DIM  = MAX_RECTS + 1;
  localparam int unsigned IDX_W     = $clog2(GRID_DIM + 1);
  localparam int unsigned DIM_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_HEIGHT = CFG_IDX_W'(1);

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_FAIL,
    OP_COL_INIT,
    OP_COL_STEP,
    OP_COL_FAIL,
    OP_NEXT_COL,
    OP_COL_HIT,
    OP_ROW_INIT,
    OP_ROW_STEP,
    OP_ROW_FAIL,
    OP_PLACE,
    OP_READ_K,
    OP_READ_KM1,
    OP_CW_SHIFT,
    OP_CW_SPLIT_HI,
    OP_CW_SPLIT_LO,
    OP_OCC_COL,
    OP_RS_INIT,
    OP_ROW_SHIFT,
    OP_RH_SPLIT_HI,
    OP_RH_SPLIT_LO,
    OP_MARK,
    OP_FINISH
  } dp_op_e;

  // status flags from datapath to controller
  typedef struct packed {
    logic full;
    logic col_end;
    logic row_end;
    logic lt_cw;
    logic lt_rh;
    logic last;
    logic occ_hit;
    logic cs_more;
    logic oc_more;
    logic rs_more;
    logic mk_more;
  } dp_status_t;

  // bits lo..hi set
  function automatic logic [GRID_DIM-1:0] range_mask(input logic [IDX_W-1:0] lo,
                                                      input logic [IDX_W-1:0] hi);
    logic [GRID_DIM-1:0] m;
    m = '0;
    for (int i = 0; i < GRID_DIM; i++) begin
      m[i] = (IDX_W'(i) >= lo) && (IDX_W'(i) <= hi);
    end
    return m;
  endfunction

  // duplicate bit ce into ce+1, shifting higher bits up by one
  function automatic logic [GRID_DIM-1:0] col_insert(input logic [GRID_DIM-1:0] row,
                                                      input logic [IDX_W-1:0] ce);
    logic [GRID_DIM-1:0] le;
    le = range_mask('0, ce);
    return (row & le) | ((row << 1) & ~le);
  endfunction

endpackage

/* hw/rtl/grp_ctrl.sv */
// grp_ctrl: sequencing state machine of the grid rectangle packer
`timescale 1ns / 1ps

module grp_ctrl import grp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output dp_op_e     op_o,
  output logic       busy_o
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_COL_BEGIN,
    S_COL_RD,
    S_COL_EV,
    S_ROW_BEGIN,
    S_ROW_RD,
    S_ROW_EV,
    S_CS_CHK,
    S_CS_WR,
    S_CS_LO,
    S_OC_CHK,
    S_OC_WR,
    S_RS_CHK,
    S_RS_WR,
    S_RH_LO,
    S_MK_CHK,
    S_MK_WR
  } state_e;

  state_e state_q, state_d;

  assign busy_o = (state_q != S_IDLE);

  // next state and datapath operation
  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_o    = OP_START;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.full) begin
          op_o    = OP_FAIL;
          state_d = S_IDLE;
        end else begin
          state_d = S_COL_BEGIN;
        end
      end
      S_COL_BEGIN: begin
        if (status_i.col_end) begin
          op_o    = OP_FAIL;
          state_d = S_IDLE;
        end else begin
          op_o    = OP_COL_INIT;
          state_d = S_COL_RD;
        end
      end
      S_COL_RD: begin
        op_o    = OP_READ_K;
        state_d = S_COL_EV;
      end
      S_COL_EV: begin
        priority if (!status_i.lt_cw) begin
          op_o    = OP_COL_HIT;
          state_d = S_ROW_BEGIN;
        end else if (status_i.last) begin
          op_o    = OP_COL_FAIL;
          state_d = S_COL_BEGIN;
        end else begin
          op_o    = OP_COL_STEP;
          state_d = S_COL_RD;
        end
      end
      S_ROW_BEGIN: begin
        if (status_i.row_end) begin
          op_o    = OP_NEXT_COL;
          state_d = S_COL_BEGIN;
        end else begin
          op_o    = OP_ROW_INIT;
          state_d = S_ROW_RD;
        end
      end
      S_ROW_RD: begin
        op_o    = OP_READ_K;
        state_d = S_ROW_EV;
      end
      S_ROW_EV: begin
        priority if (status_i.occ_hit || (status_i.lt_rh && status_i.last)) begin
          op_o    = OP_ROW_FAIL;
          state_d = S_ROW_BEGIN;
        end else if (status_i.lt_rh) begin
          op_o    = OP_ROW_STEP;
          state_d = S_ROW_RD;
        end else begin
          op_o    = OP_PLACE;
          state_d = S_CS_CHK;
        end
      end
      S_CS_CHK: begin
        if (status_i.cs_more) begin
          op_o    = OP_READ_KM1;
          state_d = S_CS_WR;
        end else begin
          op_o    = OP_CW_SPLIT_HI;
          state_d = S_CS_LO;
        end
      end
      S_CS_WR: begin
        op_o    = OP_CW_SHIFT;
        state_d = S_CS_CHK;
      end
      S_CS_LO: begin
        op_o    = OP_CW_SPLIT_LO;
        state_d = S_OC_CHK;
      end
      S_OC_CHK: begin
        if (status_i.oc_more) begin
          op_o    = OP_READ_K;
          state_d = S_OC_WR;
        end else begin
          op_o    = OP_RS_INIT;
          state_d = S_RS_CHK;
        end
      end
      S_OC_WR: begin
        op_o    = OP_OCC_COL;
        state_d = S_OC_CHK;
      end
      S_RS_CHK: begin
        if (status_i.rs_more) begin
          op_o    = OP_READ_KM1;
          state_d = S_RS_WR;
        end else begin
          op_o    = OP_RH_SPLIT_HI;
          state_d = S_RH_LO;
        end
      end
      S_RS_WR: begin
        op_o    = OP_ROW_SHIFT;
        state_d = S_RS_CHK;
      end
      S_RH_LO: begin
        op_o    = OP_RH_SPLIT_LO;
        state_d = S_MK_CHK;
      end
      S_MK_CHK: begin
        if (status_i.mk_more) begin
          op_o    = OP_READ_K;
          state_d = S_MK_WR;
        end else begin
          op_o    = OP_FINISH;
          state_d = S_IDLE;
        end
      end
      S_MK_WR: begin
        op_o    = OP_MARK;
        state_d = S_MK_CHK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/grp_dp.sv */
// grp_dp: grid memories, walk counters and result registers of the grid rectangle packer
`timescale 1ns / 1ps

module grp_dp import grp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_op_e               op_i,
  output dp_status_t           status_o,
  input  logic [DIM_W-1:0]     rect_width_i,
  input  logic [DIM_W-1:0]     rect_height_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  output logic                 done_o,
  output logic                 placed_o,
  output logic [DIM_W-1:0]     pos_x_o,
  output logic [DIM_W-1:0]     pos_y_o
);

  localparam logic [IDX_W-1:0] ONE = IDX_W'(1);

  // grid memories
  logic [DIM_W-1:0]    cw_mem  [GRID_DIM];
  logic [DIM_W-1:0]    rh_mem  [GRID_DIM];
  logic [GRID_DIM-1:0] occ_mem [GRID_DIM];

  logic [DIM_W-1:0]    cw_rd_q, rh_rd_q;
  logic [GRID_DIM-1:0] occ_rd_q;
  logic                vld_rd_q;
  logic [GRID_DIM-1:0] vld_q, vld_d;

  logic [DIM_W-1:0] bin_w_q, bin_w_d, bin_h_q, bin_h_d;
  logic [IDX_W-1:0] n_q, n_d, k_q, k_d, col_q, col_d, row_q, row_d;
  logic [IDX_W-1:0] ce_q, ce_d, re_q, re_d;
  logic [DIM_W-1:0] w_q, w_d, h_q, h_d, fill_q, fill_d;
  logic [DIM_W-1:0] fx_q, fx_d, fy_q, fy_d, cwend_q, cwend_d, rhend_q, rhend_d;
  logic [DIM_W-1:0] cwcol_q, cwcol_d, rhrow_q, rhrow_d, xsum_q, xsum_d, ysum_q, ysum_d;
  logic             done_q, done_d, placed_q, placed_d;
  logic [DIM_W-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;

  logic [IDX_W-1:0]    rd_addr;
  logic                cw_we, rh_we, occ_we;
  logic [IDX_W-1:0]    cw_waddr, rh_waddr, occ_waddr;
  logic [DIM_W-1:0]    cw_wdata, rh_wdata;
  logic [GRID_DIM-1:0] occ_wdata;

  logic [DIM_W-1:0]    cw_size, rh_size, cwcol_eff, rhrow_eff;
  logic [GRID_DIM-1:0] occ_row, blk_mask;

  // read data with the fresh-grid view: a single column and row span the bin
  assign cw_size   = (n_q == ONE) ? bin_w_q : cw_rd_q;
  assign rh_size   = (n_q == ONE) ? bin_h_q : rh_rd_q;
  assign occ_row   = vld_rd_q ? occ_rd_q : '0;
  assign blk_mask  = range_mask(col_q, ce_q);
  assign cwcol_eff = (k_q == col_q) ? cw_size : cwcol_q;
  assign rhrow_eff = (k_q == row_q) ? rh_size : rhrow_q;
  assign rd_addr   = (op_i == OP_READ_KM1) ? (k_q - ONE) : k_q;

  // status flags
  always_comb begin
    status_o.full    = (n_q == IDX_W'(GRID_DIM));
    status_o.col_end = (col_q == n_q);
    status_o.row_end = (row_q == n_q);
    status_o.lt_cw   = (cw_size < fill_q);
    status_o.lt_rh   = (rh_size < fill_q);
    status_o.last    = ((k_q + ONE) == n_q);
    status_o.occ_hit = |(occ_row & blk_mask);
    status_o.cs_more = (k_q > (ce_q + ONE));
    status_o.oc_more = (k_q < n_q);
    status_o.rs_more = (k_q > re_q);
    status_o.mk_more = (k_q <= re_q);
  end

  // memory write selection
  always_comb begin
    cw_we     = 1'b0;
    rh_we     = 1'b0;
    occ_we    = 1'b0;
    cw_waddr  = k_q;
    rh_waddr  = k_q;
    occ_waddr = k_q;
    cw_wdata  = cw_size;
    rh_wdata  = rh_size;
    occ_wdata = occ_row;
    unique case (op_i)
      OP_CW_SHIFT: begin
        cw_we = 1'b1;
      end
      OP_CW_SPLIT_HI: begin
        cw_we    = 1'b1;
        cw_waddr = ce_q + ONE;
        cw_wdata = cwend_q - fx_q;
      end
      OP_CW_SPLIT_LO: begin
        cw_we    = 1'b1;
        cw_waddr = ce_q;
        cw_wdata = fx_q;
      end
      OP_OCC_COL: begin
        occ_we    = 1'b1;
        occ_wdata = col_insert(occ_row, ce_q);
      end
      OP_ROW_SHIFT: begin
        rh_we  = 1'b1;
        occ_we = 1'b1;
      end
      OP_RH_SPLIT_HI: begin
        rh_we    = 1'b1;
        rh_waddr = re_q + ONE;
        rh_wdata = rhend_q - fy_q;
      end
      OP_RH_SPLIT_LO: begin
        rh_we    = 1'b1;
        rh_waddr = re_q;
        rh_wdata = fy_q;
      end
      OP_MARK: begin
        occ_we    = 1'b1;
        occ_wdata = occ_row | blk_mask;
      end
      default: begin
      end
    endcase
  end

  // next values of the walk and result registers
  always_comb begin
    bin_w_d  = bin_w_q;
    bin_h_d  = bin_h_q;
    n_d      = n_q;
    vld_d    = vld_q;
    k_d      = k_q;
    col_d    = col_q;
    row_d    = row_q;
    ce_d     = ce_q;
    re_d     = re_q;
    w_d      = w_q;
    h_d      = h_q;
    fill_d   = fill_q;
    fx_d     = fx_q;
    fy_d     = fy_q;
    cwend_d  = cwend_q;
    rhend_d  = rhend_q;
    cwcol_d  = cwcol_q;
    rhrow_d  = rhrow_q;
    xsum_d   = xsum_q;
    ysum_d   = ysum_q;
    done_d   = 1'b0;
    placed_d = placed_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    unique case (op_i)
      OP_START: begin
        w_d    = rect_width_i;
        h_d    = rect_height_i;
        col_d  = '0;
        xsum_d = '0;
      end
      OP_FAIL: begin
        done_d   = 1'b1;
        placed_d = 1'b0;
        pos_x_d  = '0;
        pos_y_d  = '0;
      end
      OP_COL_INIT: begin
        k_d    = col_q;
        fill_d = w_q;
      end
      OP_COL_STEP: begin
        fill_d = fill_q - cw_size;
        k_d    = k_q + ONE;
        if (k_q == col_q) begin
          cwcol_d = cw_size;
        end
      end
      OP_COL_FAIL: begin
        xsum_d = xsum_q + cwcol_eff;
        col_d  = col_q + ONE;
      end
      OP_NEXT_COL: begin
        xsum_d = xsum_q + cwcol_q;
        col_d  = col_q + ONE;
      end
      OP_COL_HIT: begin
        ce_d    = k_q;
        fx_d    = fill_q;
        cwend_d = cw_size;
        cwcol_d = cwcol_eff;
        row_d   = '0;
        ysum_d  = '0;
      end
      OP_ROW_INIT: begin
        k_d    = row_q;
        fill_d = h_q;
      end
      OP_ROW_STEP: begin
        fill_d = fill_q - rh_size;
        k_d    = k_q + ONE;
        if (k_q == row_q) begin
          rhrow_d = rh_size;
        end
      end
      OP_ROW_FAIL: begin
        ysum_d = ysum_q + rhrow_eff;
        row_d  = row_q + ONE;
      end
      OP_PLACE: begin
        re_d     = k_q;
        fy_d     = fill_q;
        rhend_d  = rh_size;
        done_d   = 1'b1;
        placed_d = 1'b1;
        pos_x_d  = xsum_q;
        pos_y_d  = ysum_q;
        k_d      = n_q;
      end
      OP_CW_SHIFT, OP_ROW_SHIFT: begin
        k_d = k_q - ONE;
      end
      OP_CW_SPLIT_LO: begin
        k_d = '0;
      end
      OP_OCC_COL, OP_MARK: begin
        k_d = k_q + ONE;
      end
      OP_RS_INIT: begin
        k_d = n_q;
      end
      OP_RH_SPLIT_LO: begin
        k_d = row_q;
      end
      OP_FINISH: begin
        n_d = n_q + ONE;
      end
      default: begin
      end
    endcase
    if (occ_we) begin
      vld_d[occ_waddr] = 1'b1;
    end
    // register write resets the grid
    if (cfg_we_i && ((cfg_index_i == CFG_BIN_WIDTH) || (cfg_index_i == CFG_BIN_HEIGHT))) begin
      if (cfg_index_i == CFG_BIN_WIDTH) begin
        bin_w_d = cfg_data_i;
      end else begin
        bin_h_d = cfg_data_i;
      end
      n_d   = ONE;
      vld_d = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_w_q  <= DIM_W'(1024);
      bin_h_q  <= DIM_W'(1024);
      n_q      <= ONE;
      vld_q    <= '0;
      k_q      <= '0;
      col_q    <= '0;
      row_q    <= '0;
      done_q   <= 1'b0;
      placed_q <= 1'b0;
    end else begin
      bin_w_q  <= bin_w_d;
      bin_h_q  <= bin_h_d;
      n_q      <= n_d;
      vld_q    <= vld_d;
      k_q      <= k_d;
      col_q    <= col_d;
      row_q    <= row_d;
      done_q   <= done_d;
      placed_q <= placed_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ce_q    <= ce_d;
    re_q    <= re_d;
    w_q     <= w_d;
    h_q     <= h_d;
    fill_q  <= fill_d;
    fx_q    <= fx_d;
    fy_q    <= fy_d;
    cwend_q <= cwend_d;
    rhend_q <= rhend_d;
    cwcol_q <= cwcol_d;
    rhrow_q <= rhrow_d;
    xsum_q  <= xsum_d;
    ysum_q  <= ysum_d;
    pos_x_q <= pos_x_d;
    pos_y_q <= pos_y_d;
  end

  // grid memories, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (cw_we) begin
      cw_mem[cw_waddr] <= cw_wdata;
    end
    if (rh_we) begin
      rh_mem[rh_waddr] <= rh_wdata;
    end
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    cw_rd_q  <= cw_mem[rd_addr];
    rh_rd_q  <= rh_mem[rd_addr];
    occ_rd_q <= occ_mem[rd_addr];
    vld_rd_q <= vld_q[rd_addr];
  end

  assign done_o   = done_q;
  assign placed_o = placed_q;
  assign pos_x_o  = pos_x_q;
  assign pos_y_o  = pos_y_q;

endmodule

/* hw/rtl/grid_rectangle_packer_unit.sv */
// grid_rectangle_packer_unit: top level of the grid-split rectangle packer
`timescale 1ns / 1ps
// Usage:
// - an item (rect_width_i, rect_height_i) is taken when start_i is high and busy_o is low
// - exactly one result per item: done_o pulses for one cycle with placed_o, pos_x_o, pos_y_o;
//   a failed item gives placed_o low and zero positions, the grid is left unchanged
// - the result shows up when the search finds a cell; busy_o stays high while the grid
//   is split and marked, and the next item is taken once busy_o drops
// - the search walks the column widths from each column tried, then the row heights from
//   each start row tried in that column; done_o follows when a cell is found or nothing fits
// - the update then keeps busy_o high while the columns and rows past the placed cell are
//   shifted, the spanned column and row are split and the covered cells are marked
// - a full grid answers with done_o high and busy_o already low
// - configuration: cfg_valid_i / cfg_ready_o with cfg_index_i (0 bin width, 1 bin height)
//   and cfg_data_i; ready while idle; any write to a known index resets the grid at once
// - reset: bin 1024 x 1024, one column and row, all cells free; no clearing pass
// - the receiver cannot stall, results are never held back

module grid_rectangle_packer_unit import grp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [DIM_W-1:0]     rect_width_i,
  input  logic [DIM_W-1:0]     rect_height_i,
  output logic                 done_o,
  output logic                 placed_o,
  output logic [DIM_W-1:0]     pos_x_o,
  output logic [DIM_W-1:0]     pos_y_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  dp_op_e     op;
  dp_status_t status;

  assign cfg_ready_o = !busy_o;

  // sequencer
  grp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .op_o     (op),
    .busy_o   (busy_o)
  );

  // grid storage and arithmetic
  grp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .status_o      (status),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .placed_o      (placed_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o)
  );

endmodule

/* sim/grid_rectangle_packer_checker.sv */
// grid_rectangle_packer_checker: predicts packer results and compares them with the block output
`timescale 1ns / 1ps

module grid_rectangle_packer_checker import grp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic [DIM_W-1:0]     rect_width_i,
  input  logic [DIM_W-1:0]     rect_height_i,
  input  logic                 done_i,
  input  logic                 placed_i,
  input  logic [DIM_W-1:0]     pos_x_i,
  input  logic [DIM_W-1:0]     pos_y_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  output int                   pending_o,
  output int                   errors_o
);

  typedef struct packed {
    logic             placed;
    logic [DIM_W-1:0] pos_x;
    logic [DIM_W-1:0] pos_y;
  } placement_t;

  placement_t       placements_q[$];
  logic [DIM_W-1:0] bin_w, bin_h;
  logic [DIM_W-1:0] col_w[GRID_DIM];
  logic [DIM_W-1:0] row_h[GRID_DIM];
  logic             occ[GRID_DIM][GRID_DIM];
  int               lines;

  assign pending_o = placements_q.size();

  // empty grid of one column and one row
  task automatic clear_grid();
    for (int i = 0; i < GRID_DIM; i++) begin
      col_w[i] = '0;
      row_h[i] = '0;
      for (int j = 0; j < GRID_DIM; j++) occ[i][j] = 1'b0;
    end
    col_w[0] = bin_w;
    row_h[0] = bin_h;
    lines = 1;
  endtask

  // walk sizes from start until need is covered
  function automatic bit walk_cols(input int start, input int need, output int last,
                                   output int rest);
    int k, fill;
    k = start;
    fill = need;
    while (k < lines && int'(col_w[k]) < fill) begin
      fill -= col_w[k];
      k++;
    end
    last = k;
    rest = fill;
    return k < lines;
  endfunction

  function automatic bit walk_rows(input int start, input int need, output int last,
                                   output int rest);
    int k, fill;
    k = start;
    fill = need;
    while (k < lines && int'(row_h[k]) < fill) begin
      fill -= row_h[k];
      k++;
    end
    last = k;
    rest = fill;
    return k < lines;
  endfunction

  // search, split and mark for one rectangle
  task automatic place_rect(input int w, input int h, output placement_t res);
    int  ce, re, fx, fy, px, py, sx, sy;
    bit  found, ok;
    res = '0;
    found = 0;
    ce = 0; re = 0; fx = 0; fy = 0; px = 0; py = 0;
    if (lines >= GRID_DIM) return;
    for (int c = 0; c < lines && !found; c++) begin
      for (int r = 0; r < lines && !found; r++) begin
        if (occ[r][c]) continue;
        if (!walk_cols(c, w, ce, fx)) continue;
        if (!walk_rows(r, h, re, fy)) continue;
        ok = 1;
        for (int rr = r; rr <= re; rr++)
          for (int cc = c; cc <= ce; cc++)
            if (occ[rr][cc]) ok = 0;
        if (ok) begin
          found = 1;
          px = c;
          py = r;
        end
      end
    end
    if (!found) return;
    sx = 0;
    sy = 0;
    for (int k = 0; k < px; k++) sx += col_w[k];
    for (int k = 0; k < py; k++) sy += row_h[k];
    res.placed = 1'b1;
    res.pos_x  = DIM_W'(sx);
    res.pos_y  = DIM_W'(sy);
    // column split
    for (int j = lines; j > ce + 1; j--) begin
      col_w[j] = col_w[j-1];
      for (int r = 0; r < GRID_DIM; r++) occ[r][j] = occ[r][j-1];
    end
    col_w[ce+1] = col_w[ce] - DIM_W'(fx);
    col_w[ce]   = DIM_W'(fx);
    for (int r = 0; r < GRID_DIM; r++) occ[r][ce+1] = occ[r][ce];
    // row split
    for (int j = lines; j > re + 1; j--) begin
      row_h[j] = row_h[j-1];
      for (int c = 0; c < GRID_DIM; c++) occ[j][c] = occ[j-1][c];
    end
    row_h[re+1] = row_h[re] - DIM_W'(fy);
    row_h[re]   = DIM_W'(fy);
    for (int c = 0; c < GRID_DIM; c++) occ[re+1][c] = occ[re][c];
    lines++;
    for (int r = py; r <= re; r++)
      for (int c = px; c <= ce; c++) occ[r][c] = 1'b1;
  endtask

  // track configuration, predict accepted items, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    placement_t exp_res, got;
    if (!rst_ni) begin
      bin_w = DIM_W'(1024);
      bin_h = DIM_W'(1024);
      clear_grid();
      placements_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_BIN_WIDTH) begin
          bin_w = cfg_data_i;
          clear_grid();
        end else if (cfg_index_i == CFG_BIN_HEIGHT) begin
          bin_h = cfg_data_i;
          clear_grid();
        end
      end
      if (start_i && !busy_i) begin
        place_rect(int'(rect_width_i), int'(rect_height_i), exp_res);
        placements_q = {placements_q, exp_res};
      end
      if (done_i) begin
        got = '{placed_i, pos_x_i, pos_y_i};
        if (placements_q.size() == 0) begin
          $display("%0t: unexpected result placed=%0b x=%0d y=%0d", $time,
                   placed_i, pos_x_i, pos_y_i);
          errors_o++;
        end else begin
          exp_res = placements_q.pop_front();
          if (got !== exp_res) begin
            $display("%0t: mismatch expected placed=%0b x=%0d y=%0d, actual placed=%0b x=%0d y=%0d",
                     $time, exp_res.placed, exp_res.pos_x, exp_res.pos_y,
                     got.placed, got.pos_x, got.pos_y);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

/* sim/grid_rectangle_packer_unit_tb.sv */
// grid_rectangle_packer_unit_tb: stimulus and verdict for the grid rectangle packer
`timescale 1ns / 1ps

module grid_rectangle_packer_unit_tb;
  import grp_pkg::*;

  localparam int SETTLE_CYCLES = 800;
  localparam int CYCLE_LIMIT   = 20000000;

  logic                 clk_i, rst_ni;
  logic                 start_i, busy_o;
  logic [DIM_W-1:0]     rect_width_i, rect_height_i;
  logic                 done_o, placed_o;
  logic [DIM_W-1:0]     pos_x_o, pos_y_o;
  logic                 cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DIM_W-1:0]     cfg_data_i;
  int                   pending, errors, cycles;
  bit                   no_gaps;

  grid_rectangle_packer_unit u_dut (.*);

  grid_rectangle_packer_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .rect_width_i, .rect_height_i,
    .done_i(done_o), .placed_i(placed_o), .pos_x_i(pos_x_o), .pos_y_i(pos_y_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // offer one rectangle, with a random gap before it unless no_gaps is set
  task automatic send_rect(input int w, input int h);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    rect_width_i  <= DIM_W'(w);
    rect_height_i <= DIM_W'(h);
    do @(posedge clk_i); while (busy_o);
  endtask

  // drain results and let the update finish, then write a register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= DIM_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_bin(input int w, input int h);
    write_reg(CFG_BIN_WIDTH, w);
    write_reg(CFG_BIN_HEIGHT, h);
  endtask

  function automatic int pick_dim(input int bin);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return bin;
      2:       return $urandom_range(0, 4095);
      default: return $urandom_range(0, bin / 3 + 1);
    endcase
  endfunction

  initial begin
    int bw, bh;
    cycles        = 0;
    no_gaps       = 0;
    start_i       = 1'b0;
    rect_width_i  = '0;
    rect_height_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_BIN_WIDTH;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset bin, zero size, oversize, exact fit, extremes
    send_rect(0, 0);
    send_rect(4095, 4095);
    send_rect(1024, 0);
    send_rect(0, 1024);
    send_rect(512, 512);
    send_rect(512, 512);
    send_rect(1024, 1024);
    set_bin(4095, 4095);
    send_rect(4095, 4095);
    send_rect(1, 1);
    send_rect(2730, 1365);
    send_rect(1365, 2730);
    // zero bin, out of range indexes ignored
    set_bin(0, 0);
    write_reg(CFG_IDX_W'(2), 4095);
    write_reg(CFG_IDX_W'(3), 1);
    send_rect(1, 0);
    send_rect(0, 1);
    send_rect(0, 0);
    set_bin(1, 4095);
    send_rect(1, 4095);
    send_rect(1, 1);
    send_rect(2048, 2048);

    // fill the grid until it is full
    set_bin(64, 64);
    no_gaps = 1;
    for (int i = 0; i < 68; i++) send_rect($urandom_range(0, 1), $urandom_range(0, 1));
    no_gaps = 0;

    // random phases, each from a fresh bin
    for (int ph = 0; ph < 4; ph++) begin
      case (ph % 4)
        0:       begin bw = 4095; bh = 4095; end
        1:       begin bw = $urandom_range(1, 32); bh = $urandom_range(1, 4095); end
        default: begin bw = $urandom_range(1, 4095); bh = $urandom_range(1, 4095); end
      endcase
      set_bin(bw, bh);
      no_gaps = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < 14; i++) begin
        send_rect(pick_dim(bw), pick_dim(bh));
        // let everything drain once mid phase
        if (ph == 3 && i == 6) begin
          start_i <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
